// File: rtl/lsbwq_pkg.sv
// Shared types and constants for the load/store buffer wakeup queue.
package lsbwq_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TAG_COUNT_DEF   = 32;
    localparam int READY_TICKS_DEF = 3;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int OFF_W  = 12;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_WAKE  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_FLUSH = 2'd3
    } t_req;

    // Controller to datapath commands.
    typedef struct packed {
        logic enq;        // write a new entry at the tail
        logic flush;      // empty the queue
        logic wake_load;  // latch the broadcast, start the sweep at head
        logic wake_run;   // sweep one entry this cycle
        logic wake_end;   // sweep finished, emit the result
        logic tick_eval;  // head entry read is back, evaluate the tick
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_end;   // sweep pointer has reached the tail
        logic wb_busy;    // a write-back of the sweep is still pending
    } t_dp_stat;

endpackage

// File: rtl/lsbwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsbwq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lsbwq_ctrl.sv
// Request sequencer for the load/store buffer wakeup queue.
module lsbwq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_req_type,
    input  lsbwq_pkg::t_dp_stat i_stat,
    output lsbwq_pkg::t_dp_cmd  o_cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_WAKE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (lsbwq_pkg::t_req'(i_req_type))
                        lsbwq_pkg::REQ_ENQ:   o_cmd.enq = 1'b1;
                        lsbwq_pkg::REQ_FLUSH: o_cmd.flush = 1'b1;
                        lsbwq_pkg::REQ_TICK:  n_state = S_TICK;
                        lsbwq_pkg::REQ_WAKE: begin
                            o_cmd.wake_load = 1'b1;
                            n_state         = S_WAKE;
                        end
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick_eval = 1'b1;
                n_state         = S_IDLE;
            end
            S_WAKE: begin
                o_cmd.wake_run = 1'b1;
                if (i_stat.scan_end && !i_stat.wb_busy) begin
                    o_cmd.wake_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/lsbwq_dp.sv
// Datapath: pointers, tick counter, entry RAMs, wakeup sweep and result registers.
module lsbwq_dp #(
    parameter int QUEUE_DEPTH = lsbwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_COUNT   = lsbwq_pkg::TAG_COUNT_DEF,
    parameter int READY_TICKS = lsbwq_pkg::READY_TICKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsbwq_pkg::t_dp_cmd             i_cmd,
    output lsbwq_pkg::t_dp_stat            o_stat,
    input  logic                           i_src1_wait,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_src1_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_src1_value,
    input  logic                           i_src2_wait,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_src2_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_src2_value,
    input  logic [lsbwq_pkg::OFF_W-1:0]    i_offset_raw,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_dest_tag,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_bcast_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_bcast_value,
    output logic                           o_valid,
    output logic                           o_queue_full,
    output logic                           o_done_res,
    output logic [$clog2(TAG_COUNT)-1:0]   o_done_dest,
    output logic [lsbwq_pkg::DATA_W-1:0]   o_done_address,
    output logic [lsbwq_pkg::DATA_W-1:0]   o_done_value
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int TAG_W  = $clog2(TAG_COUNT);
    localparam int CNT_W  = $clog2(READY_TICKS + 1);
    localparam int DATA_W = lsbwq_pkg::DATA_W;
    localparam int OFF_W  = lsbwq_pkg::OFF_W;
    // wait word: A wait, A tag, B wait, B tag
    localparam int WAIT_W = 2 * TAG_W + 2;
    localparam int A_BIT  = 2 * TAG_W + 1;
    localparam int B_BIT  = TAG_W;
    // offset/dest word: offset above dest tag
    localparam int OD_W   = OFF_W + TAG_W;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        f_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  r_scan, n_scan;
    logic              r_wb_vld, n_wb_vld;
    logic [PTR_W-1:0]  r_wb_addr;
    logic [TAG_W-1:0]  r_bc_tag;
    logic [DATA_W-1:0] r_bc_value;

    logic              r_valid, n_valid;
    logic              r_done, n_done;
    logic [TAG_W-1:0]  r_dest, n_dest;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_val, n_val;

    logic              full;
    logic              enq_ok;
    logic [PTR_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  cnt_inc;
    logic              head_ready;

    logic [DATA_W-1:0] a_rd, b_rd;
    logic [WAIT_W-1:0] wait_rd;
    logic [OD_W-1:0]   od_rd;
    logic [OFF_W-1:0]  off_rd;

    logic              a_hit, b_hit;
    logic [WAIT_W-1:0] wait_wb;

    logic              a_we, b_we, wait_we;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] a_wdata, b_wdata;
    logic [WAIT_W-1:0] wait_wdata;

    assign full    = (f_next(r_tail) == r_head);
    assign enq_ok  = i_cmd.enq && !full;
    assign rd_addr = i_cmd.wake_run ? r_scan : r_head;

    // Sweep write-back: clear the operands that wait on the broadcast tag
    assign a_hit = wait_rd[A_BIT] && (wait_rd[A_BIT-1 -: TAG_W] == r_bc_tag);
    assign b_hit = wait_rd[B_BIT] && (wait_rd[TAG_W-1:0] == r_bc_tag);
    always_comb begin
        wait_wb = wait_rd;
        if (a_hit) begin
            wait_wb[A_BIT] = 1'b0;
        end
        if (b_hit) begin
            wait_wb[B_BIT] = 1'b0;
        end
    end

    // RAM write muxes: enqueue at tail, or sweep write-back
    assign wr_addr    = r_wb_vld ? r_wb_addr : r_tail;
    assign wait_we    = enq_ok || r_wb_vld;
    assign a_we       = enq_ok || (r_wb_vld && a_hit);
    assign b_we       = enq_ok || (r_wb_vld && b_hit);
    assign wait_wdata = r_wb_vld ? wait_wb
                                 : {i_src1_wait, i_src1_tag, i_src2_wait, i_src2_tag};
    assign a_wdata    = r_wb_vld ? r_bc_value : i_src1_value;
    assign b_wdata    = r_wb_vld ? r_bc_value : i_src2_value;

    lsbwq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (wr_addr),
        .i_wdata (a_wdata),
        .i_raddr (rd_addr),
        .o_rdata (a_rd)
    );

    lsbwq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (wr_addr),
        .i_wdata (b_wdata),
        .i_raddr (rd_addr),
        .o_rdata (b_rd)
    );

    lsbwq_ram #(.WIDTH(WAIT_W), .DEPTH(QUEUE_DEPTH)) u_ram_wait (
        .i_clk   (i_clk),
        .i_we    (wait_we),
        .i_waddr (wr_addr),
        .i_wdata (wait_wdata),
        .i_raddr (rd_addr),
        .o_rdata (wait_rd)
    );

    lsbwq_ram #(.WIDTH(OD_W), .DEPTH(QUEUE_DEPTH)) u_ram_od (
        .i_clk   (i_clk),
        .i_we    (enq_ok),
        .i_waddr (r_tail),
        .i_wdata ({i_offset_raw, i_dest_tag}),
        .i_raddr (rd_addr),
        .o_rdata (od_rd)
    );

    assign off_rd     = od_rd[OD_W-1:TAG_W];
    assign cnt_inc    = r_cnt + CNT_W'(1);
    assign head_ready = (r_head != r_tail) && !wait_rd[A_BIT] && !wait_rd[B_BIT];

    // Pointer, counter, sweep and result next-state
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_scan   = r_scan;
        n_wb_vld = r_wb_vld;
        n_valid  = i_cmd.enq || i_cmd.flush || i_cmd.tick_eval || i_cmd.wake_end;
        n_done   = 1'b0;
        n_dest   = '0;
        n_addr   = '0;
        n_val    = '0;

        if (enq_ok) begin
            n_tail = f_next(r_tail);
        end
        if (i_cmd.flush) begin
            n_head = '0;
            n_tail = '0;
            n_cnt  = '0;
        end
        if (i_cmd.wake_load) begin
            n_scan   = r_head;
            n_wb_vld = 1'b0;
        end
        if (i_cmd.wake_run) begin
            n_wb_vld = (r_scan != r_tail);
            if (r_scan != r_tail) begin
                n_scan = f_next(r_scan);
            end
        end
        if (i_cmd.tick_eval && head_ready) begin
            if (cnt_inc == CNT_W'(READY_TICKS)) begin
                n_done = 1'b1;
                n_dest = od_rd[TAG_W-1:0];
                n_addr = a_rd + {{(DATA_W - OFF_W){off_rd[OFF_W-1]}}, off_rd};
                n_val  = b_rd;
                n_head = f_next(r_head);
                n_cnt  = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_wb_vld <= 1'b0;
            r_valid  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_wb_vld <= n_wb_vld;
            r_valid  <= n_valid;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_wb_addr <= r_scan;
        r_dest    <= n_dest;
        r_addr    <= n_addr;
        r_val     <= n_val;
        if (i_cmd.wake_load) begin
            r_bc_tag   <= i_bcast_tag;
            r_bc_value <= i_bcast_value;
        end
    end

    assign o_stat.scan_end = (r_scan == r_tail);
    assign o_stat.wb_busy  = r_wb_vld;

    assign o_valid        = r_valid;
    assign o_queue_full   = full;
    assign o_done_res     = r_done;
    assign o_done_dest    = r_dest;
    assign o_done_address = r_addr;
    assign o_done_value   = r_val;

endmodule

// File: rtl/load_store_buffer_wakeup_queue_unit.sv
// Top level of the load/store buffer wakeup queue.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------------
//  request   | start in, busy out        | i_req_type, i_src1_*, i_src2_*, i_offset_raw,
//            |                           | i_dest_tag, i_bcast_tag, i_bcast_value
//  result    | o_valid out (one cycle)   | o_queue_full, o_done_res, o_done_dest,
//            |                           | o_done_address, o_done_value
//
//  Enqueue and flush leave busy low; their result strobes the next cycle.
//  Tick holds busy while the head entry is read from the RAMs; the result follows.
//  Wakeup holds busy until the sweep is done: the sweep reads one
//  entry a cycle through the wait-tag RAM read port and writes it back the next.
//  Synchronous active-low reset empties the queue and clears the tick counter.
//  Every request gives exactly one result; the receiver cannot stall it.
module load_store_buffer_wakeup_queue_unit #(
    parameter int QUEUE_DEPTH = lsbwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_COUNT   = lsbwq_pkg::TAG_COUNT_DEF,
    parameter int READY_TICKS = lsbwq_pkg::READY_TICKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic                           i_src1_wait,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_src1_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_src1_value,
    input  logic                           i_src2_wait,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_src2_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_src2_value,
    input  logic [lsbwq_pkg::OFF_W-1:0]    i_offset_raw,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_dest_tag,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_bcast_tag,
    input  logic [lsbwq_pkg::DATA_W-1:0]   i_bcast_value,
    output logic                           o_valid,
    output logic                           o_queue_full,
    output logic                           o_done_res,
    output logic [$clog2(TAG_COUNT)-1:0]   o_done_dest,
    output logic [lsbwq_pkg::DATA_W-1:0]   o_done_address,
    output logic [lsbwq_pkg::DATA_W-1:0]   o_done_value
);

    lsbwq_pkg::t_dp_cmd  cmd;
    lsbwq_pkg::t_dp_stat stat;

    lsbwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    lsbwq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_COUNT   (TAG_COUNT),
        .READY_TICKS (READY_TICKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_src1_wait    (i_src1_wait),
        .i_src1_tag     (i_src1_tag),
        .i_src1_value   (i_src1_value),
        .i_src2_wait    (i_src2_wait),
        .i_src2_tag     (i_src2_tag),
        .i_src2_value   (i_src2_value),
        .i_offset_raw   (i_offset_raw),
        .i_dest_tag     (i_dest_tag),
        .i_bcast_tag    (i_bcast_tag),
        .i_bcast_value  (i_bcast_value),
        .o_valid        (o_valid),
        .o_queue_full   (o_queue_full),
        .o_done_res     (o_done_res),
        .o_done_dest    (o_done_dest),
        .o_done_address (o_done_address),
        .o_done_value   (o_done_value)
    );

    // Results only come out once the sequencer is back to taking requests
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Enqueue and flush requests answer on the next cycle
    a_fast_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == lsbwq_pkg::REQ_ENQ ||
                            i_req_type == lsbwq_pkg::REQ_FLUSH)) |=> o_valid)
        else $error("enqueue or flush gave no result");

    // A completion only travels with a result strobe
    a_done_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done_res |-> o_valid)
        else $error("completion without result strobe");

    // Busy only rises on an accepted request
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

// File: bench/tb_load_store_buffer_wakeup_queue_unit.sv
// Self-checking bench for the load/store buffer wakeup queue unit.
module tb_load_store_buffer_wakeup_queue_unit;

    localparam int DEPTH       = lsbwq_pkg::QUEUE_DEPTH_DEF;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int TAG_W       = $clog2(lsbwq_pkg::TAG_COUNT_DEF);
    localparam int DATA_W      = lsbwq_pkg::DATA_W;
    localparam int OFF_W       = lsbwq_pkg::OFF_W;
    localparam int READY_TICKS = lsbwq_pkg::READY_TICKS_DEF;
    localparam int N_RANDOM    = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;   // longest wakeup sweep plus margin

    // One request as it appears on the ports
    typedef struct {
        lsbwq_pkg::t_req   kind;
        logic              src1_wait;
        logic [TAG_W-1:0]  src1_tag;
        logic [DATA_W-1:0] src1_value;
        logic              src2_wait;
        logic [TAG_W-1:0]  src2_tag;
        logic [DATA_W-1:0] src2_value;
        logic [OFF_W-1:0]  offset_raw;
        logic [TAG_W-1:0]  dest_tag;
        logic [TAG_W-1:0]  bcast_tag;
        logic [DATA_W-1:0] bcast_value;
    } t_lsq_req;

    // Request plus sender timing
    typedef struct {
        t_lsq_req    req;
        int unsigned gap;
        bit          drain_first;
    } t_stim;

    // Result fields
    typedef struct {
        logic              full;
        logic              done;
        logic [TAG_W-1:0]  dest;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] value;
    } t_lsq_res;

    // One buffer slot
    typedef struct {
        logic [DATA_W-1:0] a_val;
        logic [DATA_W-1:0] b_val;
        logic              a_wait;
        logic [TAG_W-1:0]  a_tag;
        logic              b_wait;
        logic [TAG_W-1:0]  b_tag;
        logic [OFF_W-1:0]  offset;
        logic [TAG_W-1:0]  dest;
    } t_lsq_slot;

    // DUT signals
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic [1:0]        i_req_type     = '0;
    logic              i_src1_wait    = 1'b0;
    logic [TAG_W-1:0]  i_src1_tag     = '0;
    logic [DATA_W-1:0] i_src1_value   = '0;
    logic              i_src2_wait    = 1'b0;
    logic [TAG_W-1:0]  i_src2_tag     = '0;
    logic [DATA_W-1:0] i_src2_value   = '0;
    logic [OFF_W-1:0]  i_offset_raw   = '0;
    logic [TAG_W-1:0]  i_dest_tag     = '0;
    logic [TAG_W-1:0]  i_bcast_tag    = '0;
    logic [DATA_W-1:0] i_bcast_value  = '0;
    logic              o_valid;
    logic              o_queue_full;
    logic              o_done_res;
    logic [TAG_W-1:0]  o_done_dest;
    logic [DATA_W-1:0] o_done_address;
    logic [DATA_W-1:0] o_done_value;

    // Predictor state
    t_lsq_slot         lsq_mem [DEPTH];
    logic [PTR_W-1:0]  lsq_head    = '0;
    logic [PTR_W-1:0]  lsq_tail    = '0;
    logic [3:0]        ready_ticks = '0;

    // Bench bookkeeping
    t_stim       request_fifo [$];
    t_lsq_res    pending_results [$];
    t_stim       cur;
    bit          staged      = 1'b0;
    bit          calm        = 1'b1;
    bit          hold_first  = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned n_queued    = 0;
    int unsigned n_sent      = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned cycle_count = 0;
    int unsigned n_enq = 0, n_drop = 0, n_wake = 0, n_tick = 0, n_flush = 0, n_done = 0;

    load_store_buffer_wakeup_queue_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_src1_wait    (i_src1_wait),
        .i_src1_tag     (i_src1_tag),
        .i_src1_value   (i_src1_value),
        .i_src2_wait    (i_src2_wait),
        .i_src2_tag     (i_src2_tag),
        .i_src2_value   (i_src2_value),
        .i_offset_raw   (i_offset_raw),
        .i_dest_tag     (i_dest_tag),
        .i_bcast_tag    (i_bcast_tag),
        .i_bcast_value  (i_bcast_value),
        .o_valid        (o_valid),
        .o_queue_full   (o_queue_full),
        .o_done_res     (o_done_res),
        .o_done_dest    (o_done_dest),
        .o_done_address (o_done_address),
        .o_done_value   (o_done_value)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [PTR_W-1:0] slot_after(logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % DEPTH);
    endfunction

    // Apply one accepted request to the shadow buffer, return the expected result
    function automatic t_lsq_res lsq_advance(t_lsq_req r);
        t_lsq_res          res;
        logic [PTR_W-1:0]  i;
        logic [DATA_W-1:0] off_ext;
        res = '{default: '0};
        case (r.kind)
            lsbwq_pkg::REQ_ENQ: begin
                if (slot_after(lsq_tail) != lsq_head) begin
                    lsq_mem[lsq_tail] = '{a_val: r.src1_value, b_val: r.src2_value,
                                          a_wait: r.src1_wait, a_tag: r.src1_tag,
                                          b_wait: r.src2_wait, b_tag: r.src2_tag,
                                          offset: r.offset_raw, dest: r.dest_tag};
                    lsq_tail = slot_after(lsq_tail);
                    n_enq++;
                end else begin
                    n_drop++;
                end
            end
            lsbwq_pkg::REQ_WAKE: begin
                n_wake++;
                // each operand of each occupied slot wakes on its own
                for (i = lsq_head; i != lsq_tail; i = slot_after(i)) begin
                    if (lsq_mem[i].a_wait && lsq_mem[i].a_tag == r.bcast_tag) begin
                        lsq_mem[i].a_wait = 1'b0;
                        lsq_mem[i].a_val  = r.bcast_value;
                    end
                    if (lsq_mem[i].b_wait && lsq_mem[i].b_tag == r.bcast_tag) begin
                        lsq_mem[i].b_wait = 1'b0;
                        lsq_mem[i].b_val  = r.bcast_value;
                    end
                end
            end
            lsbwq_pkg::REQ_TICK: begin
                n_tick++;
                if (lsq_head != lsq_tail && !lsq_mem[lsq_head].a_wait
                        && !lsq_mem[lsq_head].b_wait) begin
                    ready_ticks = ready_ticks + 4'd1;
                    if (int'(ready_ticks) >= READY_TICKS) begin
                        off_ext = {{(DATA_W-OFF_W){lsq_mem[lsq_head].offset[OFF_W-1]}},
                                   lsq_mem[lsq_head].offset};
                        res.done    = 1'b1;
                        res.dest    = lsq_mem[lsq_head].dest;
                        res.address = lsq_mem[lsq_head].a_val + off_ext;
                        res.value   = lsq_mem[lsq_head].b_val;
                        lsq_head    = slot_after(lsq_head);
                        ready_ticks = '0;
                        n_done++;
                    end
                end
            end
            default: begin
                lsq_head    = '0;
                lsq_tail    = '0;
                ready_ticks = '0;
                n_flush++;
            end
        endcase
        res.full = (slot_after(lsq_tail) == lsq_head);
        return res;
    endfunction

    // Data word biased toward the extremes
    function automatic logic [DATA_W-1:0] word_draw();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_lsq_req rand_req(lsbwq_pkg::t_req k);
        t_lsq_req r;
        r.kind        = k;
        r.src1_wait   = 1'($urandom_range(0, 1));
        r.src1_tag    = TAG_W'($urandom);
        r.src1_value  = word_draw();
        r.src2_wait   = 1'($urandom_range(0, 1));
        r.src2_tag    = TAG_W'($urandom);
        r.src2_value  = word_draw();
        r.offset_raw  = OFF_W'($urandom);
        r.dest_tag    = TAG_W'($urandom);
        r.bcast_tag   = TAG_W'($urandom);
        r.bcast_value = word_draw();
        return r;
    endfunction

    // Queue one request; idle gap drawn unless in a calm stretch
    task automatic add(t_lsq_req r);
        t_stim s;
        s.req         = r;
        s.gap         = calm ? 0 : $urandom_range(0, 9);
        s.drain_first = hold_first;
        hold_first    = 1'b0;
        request_fifo.push_back(s);
        n_queued++;
    endtask

    task automatic add_ticks(int unsigned n);
        for (int unsigned j = 0; j < n; j++) add(rand_req(lsbwq_pkg::REQ_TICK));
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    // Driver: hold start until accepted, then present the next request after its gap
    always @(posedge i_clk) begin : driver
        bit launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) n_sent++;
            if (!(start && busy)) begin
                if (!staged && request_fifo.size() > 0) begin
                    cur      = request_fifo.pop_front();
                    gap_left = cur.gap;
                    staged   = 1'b1;
                end
                if (staged) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!cur.drain_first || n_results == n_sent) begin
                        staged        = 1'b0;
                        launch        = 1'b1;
                        i_req_type    <= cur.req.kind;
                        i_src1_wait   <= cur.req.src1_wait;
                        i_src1_tag    <= cur.req.src1_tag;
                        i_src1_value  <= cur.req.src1_value;
                        i_src2_wait   <= cur.req.src2_wait;
                        i_src2_tag    <= cur.req.src2_tag;
                        i_src2_value  <= cur.req.src2_value;
                        i_offset_raw  <= cur.req.offset_raw;
                        i_dest_tag    <= cur.req.dest_tag;
                        i_bcast_tag   <= cur.req.bcast_tag;
                        i_bcast_value <= cur.req.bcast_value;
                    end
                end
                start <= launch;
            end
        end
    end

    // Monitor: check results against the oldest expectation, predict accepted requests
    always @(posedge i_clk) begin : monitor
        t_lsq_res want;
        t_lsq_req seen;
        if (i_rst_n) begin
            if (o_valid) begin
                n_results <= n_results + 1;
                if (pending_results.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("queue_full",   32'(want.full),    32'(o_queue_full));
                    check_field("done_res",     32'(want.done),    32'(o_done_res));
                    check_field("done_dest",    32'(want.dest),    32'(o_done_dest));
                    check_field("done_address", want.address,     o_done_address);
                    check_field("done_value",   want.value,       o_done_value);
                end
            end
            if (start && !busy) begin
                seen.kind        = lsbwq_pkg::t_req'(i_req_type);
                seen.src1_wait   = i_src1_wait;
                seen.src1_tag    = i_src1_tag;
                seen.src1_value  = i_src1_value;
                seen.src2_wait   = i_src2_wait;
                seen.src2_tag    = i_src2_tag;
                seen.src2_value  = i_src2_value;
                seen.offset_raw  = i_offset_raw;
                seen.dest_tag    = i_dest_tag;
                seen.bcast_tag   = i_bcast_tag;
                seen.bcast_value = i_bcast_value;
                pending_results.push_back(lsq_advance(seen));
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("load_store_buffer_wakeup_queue_unit regression: fail");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        t_lsq_req    r;
        logic [TAG_W-1:0] tags [$];
        int unsigned k;
        int unsigned mode;

        foreach (lsq_mem[j]) lsq_mem[j] = '{default: '0};

        // Directed: empty queue, wrap, negative offsets, wakeups, flush
        calm = 1'b1;
        add(rand_req(lsbwq_pkg::REQ_TICK));             // tick on empty queue
        r = rand_req(lsbwq_pkg::REQ_WAKE); r.bcast_tag = '1;   // wakeup on empty queue
        add(r);
        r = rand_req(lsbwq_pkg::REQ_ENQ);               // ready operands, address wraps
        r.src1_wait = 1'b0; r.src1_tag = '1; r.src1_value = 32'hFFFF_FFF0;
        r.src2_wait = 1'b0; r.src2_tag = '1; r.src2_value = '0;
        r.offset_raw = 12'h010; r.dest_tag = '1;
        add(r);
        add_ticks(3);
        r = rand_req(lsbwq_pkg::REQ_ENQ);               // both operands wait on one tag
        r.src1_wait = 1'b1; r.src1_tag = TAG_W'(5);
        r.src2_wait = 1'b1; r.src2_tag = TAG_W'(5);
        r.offset_raw = 12'h800; r.dest_tag = '0;
        add(r);
        add_ticks(1);                                   // head not ready
        r = rand_req(lsbwq_pkg::REQ_WAKE); r.bcast_tag = TAG_W'(6);   // unmatched tag
        add(r);
        r = rand_req(lsbwq_pkg::REQ_WAKE); r.bcast_tag = TAG_W'(5); r.bcast_value = '1;
        add(r);
        add_ticks(3);
        r = rand_req(lsbwq_pkg::REQ_ENQ);
        r.src1_wait = 1'b1; r.src1_tag = '0; r.src2_wait = 1'b0; r.src2_value = '1;
        r.offset_raw = 12'h7FF;
        add(r);
        r = rand_req(lsbwq_pkg::REQ_ENQ);
        r.src1_wait = 1'b0; r.src1_value = '0; r.src2_wait = 1'b1; r.src2_tag = '1;
        r.offset_raw = 12'hFFF;
        add(r);
        add_ticks(1);
        r = rand_req(lsbwq_pkg::REQ_WAKE); r.bcast_tag = '0; r.bcast_value = 32'h1234_5678;
        add(r);
        r = rand_req(lsbwq_pkg::REQ_WAKE); r.bcast_tag = '1; r.bcast_value = '0;
        add(r);
        add_ticks(2);                                   // counter part way
        add(rand_req(lsbwq_pkg::REQ_FLUSH));            // flush clears the counter too
        r = rand_req(lsbwq_pkg::REQ_ENQ); r.src1_wait = 1'b0; r.src2_wait = 1'b0;
        add(r);
        add_ticks(3);

        // Random: mostly enqueue / wakeup / tick sequences, some fills, flushes and noise
        hold_first = 1'b1;
        while (n_queued < N_RANDOM + 25) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 49) == 0) hold_first = 1'b1;
            mode = $urandom_range(0, 99);
            if (mode < 55) begin
                k = $urandom_range(1, 4);
                tags.delete();
                for (int unsigned j = 0; j < k; j++) begin
                    r = rand_req(lsbwq_pkg::REQ_ENQ);
                    if (r.src1_wait) tags.push_back(r.src1_tag);
                    if (r.src2_wait) tags.push_back(r.src2_tag);
                    add(r);
                end
                foreach (tags[j]) begin
                    if ($urandom_range(0, 3) == 0) add(rand_req(lsbwq_pkg::REQ_TICK));
                    if ($urandom_range(0, 6) != 0) begin
                        r = rand_req(lsbwq_pkg::REQ_WAKE);
                        r.bcast_tag = tags[j];
                        add(r);
                    end
                end
                add_ticks(3 * k + $urandom_range(0, 3));
            end else if (mode < 65) begin
                // fill toward or past full so enqueues may get dropped, then drain
                if ($urandom_range(0, 1) == 0) add(rand_req(lsbwq_pkg::REQ_FLUSH));
                k = $urandom_range(DEPTH - 6, DEPTH + 3);
                for (int unsigned j = 0; j < k; j++) begin
                    r = rand_req(lsbwq_pkg::REQ_ENQ);
                    r.src1_wait = 1'b0;
                    r.src2_wait = 1'b0;
                    add(r);
                end
                add_ticks(3 * k + 3);
            end else if (mode < 70) begin
                add(rand_req(lsbwq_pkg::REQ_FLUSH));
            end else begin
                k = $urandom_range(1, 6);
                for (int unsigned j = 0; j < k; j++)
                    add(rand_req(lsbwq_pkg::t_req'($urandom_range(0, 3))));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_queued);
        wait (n_results >= n_sent);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_errors++;
        end

        $display("covered %0d requests: %0d enqueued, %0d dropped on full, %0d wakeups,",
                 n_sent, n_enq, n_drop, n_wake);
        $display("  %0d ticks, %0d flushes, %0d completions; %0d results checked",
                 n_tick, n_flush, n_done, n_results);
        if (n_errors == 0)
            $display("load_store_buffer_wakeup_queue_unit regression: pass");
        else
            $display("load_store_buffer_wakeup_queue_unit regression: fail");
        $finish;
    end

endmodule
